// ===== sv/ags_pkg.sv =====
// ----------------------------------------------------------------------------
// ags_pkg : airspeed gain scaler shared types and constants
// Register indexes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package ags_pkg;

  localparam int MIN_SPEED_FLOOR_DEF = 1280;
  localparam int VTOL_SUPPORT_DEF    = 1;

  localparam logic [2:0] REG_UNITY_SPEED      = 3'd0;
  localparam logic [2:0] REG_MIN_AIRSPEED     = 3'd1;
  localparam logic [2:0] REG_MAX_AIRSPEED     = 3'd2;
  localparam logic [2:0] REG_CRUISE_THROTTLE  = 3'd3;
  localparam logic [2:0] REG_SUPPRESS_TAKEOFF = 3'd4;

  localparam logic [15:0] Q_ONE    = 16'd4096;
  localparam logic [15:0] Q_HALF   = 16'd2048;
  localparam logic [15:0] Q_TWO    = 16'd8192;
  localparam logic [15:0] RAMP_LO  = 16'd4;
  localparam logic [15:0] SQRT_MIN = 16'd2457;
  localparam logic [15:0] SQRT_MAX = 16'd6840;

  // Division unit operand width
  localparam int DW = 32;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV_SMIN, ST_DIV_SMAX, ST_DIV_MAIN, ST_DIV_HIGH,
    ST_DIV_RAMP, ST_DIV_THR, ST_SQRT, ST_OUT
  } ags_state_t;

  typedef enum logic [2:0] {
    OP_SMIN, OP_SMAX, OP_MAIN, OP_HIGH, OP_RAMP, OP_THR
  } ags_op_t;

  typedef struct packed {
    logic    load;      // capture item
    logic    start;     // start iterative unit
    ags_op_t op;
    logic    sqrt_sel;  // run square root rather than divide
    logic    capture;   // latch step result
    logic    finish;    // form result
  } ags_cmd_t;

  typedef struct packed {
    logic busy;
    logic valid;
    logic armed;
    logic ramp_on;
  } ags_stat_t;

endpackage

// ===== sv/ags_ctrl.sv =====
// ----------------------------------------------------------------------------
// ags_ctrl : sequencer
// Steps the shared divide / square-root unit through one request.
// ----------------------------------------------------------------------------
module ags_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic               out_free,
  input  ags_pkg::ags_stat_t stat,
  output ags_pkg::ags_cmd_t  cmd,
  output logic               idle
);

  ags_pkg::ags_state_t state, state_next;
  logic                started, started_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ags_pkg::ST_IDLE;
      started <= 1'b0;
    end else begin
      state   <= state_next;
      started <= started_next;
    end
  end

  always_comb begin
    state_next   = state;
    started_next = started;
    cmd          = '0;
    cmd.op       = ags_pkg::OP_SMIN;
    idle         = 1'b0;
    unique case (state)
      ags_pkg::ST_IDLE: begin
        idle = 1'b1;
        if (in_fire) begin
          cmd.load     = 1'b1;
          started_next = 1'b0;
          state_next   = ags_pkg::ST_DIV_SMIN;
        end
      end
      ags_pkg::ST_OUT: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = ags_pkg::ST_IDLE;
        end
      end
      default: begin
        unique case (state)
          ags_pkg::ST_DIV_SMIN: cmd.op = ags_pkg::OP_SMIN;
          ags_pkg::ST_DIV_SMAX: cmd.op = ags_pkg::OP_SMAX;
          ags_pkg::ST_DIV_MAIN: cmd.op = ags_pkg::OP_MAIN;
          ags_pkg::ST_DIV_HIGH: cmd.op = ags_pkg::OP_HIGH;
          ags_pkg::ST_DIV_RAMP: cmd.op = ags_pkg::OP_RAMP;
          ags_pkg::ST_DIV_THR:  cmd.op = ags_pkg::OP_THR;
          default:              cmd.op = ags_pkg::OP_THR;
        endcase
        cmd.sqrt_sel = (state == ags_pkg::ST_SQRT);
        if (!started) begin
          cmd.start    = 1'b1;
          started_next = 1'b1;
        end else if (!stat.busy) begin
          cmd.capture  = 1'b1;
          started_next = 1'b0;
          unique case (state)
            ags_pkg::ST_DIV_SMIN: state_next = stat.valid ? ags_pkg::ST_DIV_SMAX
                                                          : (stat.armed ? ags_pkg::ST_DIV_THR
                                                                        : ags_pkg::ST_OUT);
            ags_pkg::ST_DIV_SMAX: state_next = ags_pkg::ST_DIV_MAIN;
            ags_pkg::ST_DIV_MAIN: state_next = stat.ramp_on ? ags_pkg::ST_DIV_HIGH
                                                            : ags_pkg::ST_OUT;
            ags_pkg::ST_DIV_HIGH: state_next = ags_pkg::ST_DIV_RAMP;
            ags_pkg::ST_DIV_THR:  state_next = ags_pkg::ST_SQRT;
            default:              state_next = ags_pkg::ST_OUT;
          endcase
        end
      end
    endcase
  end

endmodule

// ===== sv/ags_dp.sv =====
// ----------------------------------------------------------------------------
// ags_dp : datapath
// Item registers, shared restoring divider / square root, result forming.
// ----------------------------------------------------------------------------
module ags_dp #(
  parameter int MIN_SPEED_FLOOR = ags_pkg::MIN_SPEED_FLOOR_DEF,
  parameter int VTOL_SUPPORT    = ags_pkg::VTOL_SUPPORT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ags_pkg::ags_cmd_t  cmd,
  output ags_pkg::ags_stat_t stat,
  input  logic [14:0]        unity_speed,
  input  logic [14:0]        min_airspeed,
  input  logic [14:0]        max_airspeed,
  input  logic [6:0]         cruise_throttle,
  input  logic               suppress_takeoff,
  input  logic               speed_valid,
  input  logic [15:0]        airspeed,
  input  logic               armed,
  input  logic               vtol_active,
  input  logic signed [7:0]  throttle_cmd,
  input  logic               sensor_in_use,
  input  logic               in_takeoff,
  output logic [15:0]        gain_scale,
  output logic               decay_integrators,
  output logic [15:0]        peak_airspeed
);

  localparam int DW = ags_pkg::DW;
  localparam logic [14:0] FLOOR = 15'(MIN_SPEED_FLOOR);

  logic        r_valid, r_armed, r_vtol, r_sensor, r_takeoff;
  logic [15:0] r_speed;
  logic [6:0]  r_thr;
  logic signed [7:0] r_throttle;
  logic [15:0] peak_speed;
  logic [14:0] amin;
  logic [15:0] smin, smax, scaler, high;
  logic        ramp_on, ramp_neg;
  logic [15:0] ramp_q;

  // iterative unit
  logic [DW-1:0] num, den, quo, rem, sq_r, sq_bit;
  logic [5:0]    cnt;
  logic          busy;
  logic [DW:0]   trial;
  logic [DW-1:0] rem_sh;
  logic [DW-1:0] op_num, op_den;

  assign amin    = (min_airspeed > FLOOR) ? min_airspeed : FLOOR;
  assign ramp_on = (VTOL_SUPPORT != 0) && r_vtol && r_armed && (amin != 15'd0)
                   && ({r_speed, 1'b0} < {2'b0, amin});

  function automatic logic [15:0] sat(input logic [DW-1:0] v);
    sat = (v > DW'(65535)) ? 16'hFFFF : v[15:0];
  endfunction

  always_comb begin
    op_num = '0;
    op_den = DW'(1);
    unique case (cmd.op)
      ags_pkg::OP_SMIN: begin
        op_num = DW'({unity_speed, 11'd0});
        op_den = DW'(max_airspeed);
      end
      ags_pkg::OP_SMAX: begin
        op_num = DW'(unity_speed) * DW'(40960);
        op_den = DW'(amin) * DW'(7);
      end
      ags_pkg::OP_MAIN: begin
        op_num = DW'({unity_speed, 12'd0});
        op_den = DW'(r_speed);
      end
      ags_pkg::OP_HIGH: begin
        op_num = DW'({unity_speed, 13'd0});
        op_den = DW'(amin);
      end
      ags_pkg::OP_RAMP: begin
        op_num = DW'({r_speed, 1'b0}) * DW'(ramp_neg ? (16'd4 - high) : (high - 16'd4));
        op_den = DW'(amin);
      end
      default: begin
        op_num = DW'({r_thr, 24'd0});
        op_den = (r_throttle < 8'sd1) ? DW'(1) : DW'(r_throttle[6:0]);
      end
    endcase
  end

  assign rem_sh = {rem[DW-2:0], num[DW-1]};
  assign trial  = {1'b0, sq_r} + {1'b0, sq_bit};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      peak_speed <= '0;
    end else begin
      if (cmd.load && speed_valid && armed && (airspeed > peak_speed))
        peak_speed <= airspeed;
      if (cmd.start) begin
        busy <= 1'b1;
        if (cmd.sqrt_sel) begin
          num    <= quo;
          sq_r   <= '0;
          sq_bit <= DW'(1) << (DW - 2);
          cnt    <= 6'(DW / 2);
        end else begin
          num <= op_num;
          den <= op_den;
          quo <= '0;
          rem <= '0;
          cnt <= 6'(DW);
        end
      end else if (busy) begin
        if (cnt == 6'd1) busy <= 1'b0;
        cnt <= cnt - 6'd1;
        if (cmd.sqrt_sel) begin
          if ({1'b0, num} >= trial) begin
            num  <= num - trial[DW-1:0];
            sq_r <= (sq_r >> 1) + sq_bit;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_bit <= sq_bit >> 2;
        end else begin
          num <= {num[DW-2:0], 1'b0};
          if (rem_sh >= den) begin
            rem <= rem_sh - den;
            quo <= {quo[DW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[DW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // capture item and per-step results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_valid    <= speed_valid;
      r_speed    <= airspeed;
      r_armed    <= armed;
      r_vtol     <= vtol_active;
      r_thr      <= cruise_throttle;
      r_throttle <= throttle_cmd;
      r_sensor   <= sensor_in_use;
      r_takeoff  <= in_takeoff;
      scaler     <= ags_pkg::Q_ONE;
      ramp_q     <= 16'hFFFF;
    end
    if (cmd.capture) begin
      unique case (cmd.op)
        ags_pkg::OP_SMIN: smin <= (max_airspeed == 15'd0) ? ags_pkg::Q_HALF :
                                  ((quo < DW'(2048)) ? quo[15:0] : ags_pkg::Q_HALF);
        ags_pkg::OP_SMAX: smax <= (sat(quo) > ags_pkg::Q_TWO) ? sat(quo) : ags_pkg::Q_TWO;
        ags_pkg::OP_MAIN: scaler <= (r_speed == 16'd0) ? smax : sat(quo);
        ags_pkg::OP_HIGH: begin
          high     <= sat(quo);
          ramp_neg <= sat(quo) < 16'd4;
        end
        ags_pkg::OP_RAMP: ramp_q <= ramp_neg ? (16'd4 - quo[15:0]) : (16'd4 + quo[15:0]);
        default: if (cmd.sqrt_sel) begin
          scaler <= (sq_r < DW'(ags_pkg::SQRT_MIN)) ? ags_pkg::SQRT_MIN :
                    (sq_r > DW'(ags_pkg::SQRT_MAX)) ? ags_pkg::SQRT_MAX : sq_r[15:0];
        end
      endcase
    end
  end

  logic [15:0] s_clamp, s_fin;
  always_comb begin
    s_clamp = scaler;
    if (r_valid) begin
      if (s_clamp < smin) s_clamp = smin;
      if (s_clamp > smax) s_clamp = smax;
      if (ramp_on && ramp_q < s_clamp) s_clamp = ramp_q;
    end
    s_fin = s_clamp;
    if (!r_sensor && suppress_takeoff && r_takeoff && s_fin > ags_pkg::Q_ONE)
      s_fin = ags_pkg::Q_ONE;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      gain_scale        <= s_fin;
      decay_integrators <= r_valid && ramp_on;
      peak_airspeed     <= peak_speed;
    end
  end

  assign stat.busy    = busy;
  assign stat.valid   = r_valid;
  assign stat.armed   = r_armed;
  assign stat.ramp_on = ramp_on;

endmodule

// ===== sv/airspeed_gain_scaler_core.sv =====
// ----------------------------------------------------------------------------
// airspeed_gain_scaler_core : control-surface gain scaler
// One request per control tick gives gain scaler, decay flag and peak speed.
// ----------------------------------------------------------------------------
// s_axis carries one request; m_axis returns one result per request.
// cfg_* writes a register by index; the user must do so only while the
// block is idle, as the block itself does not enforce it. A shared radix-2
// restoring divider and a one-bit-a-step square root serve each request,
// with a start and a capture step around each run. Steps per request:
//   no airspeed, not armed   : min divide
//   airspeed valid           : min, max, main; high, ramp at low speed
//   no airspeed, armed       : min divide, throttle divide, square root
// One request is in work at a time; s_axis_tready is high when idle, so a
// new request is taken only once the previous one has been finished.
// The result sits in an output register until taken, while the next
// request is accepted; the sequencer waits if the previous result is
// still held. Reset clears registers to defaults and peak speed to zero.
// ----------------------------------------------------------------------------
module airspeed_gain_scaler_core #(
  parameter int MIN_SPEED_FLOOR = ags_pkg::MIN_SPEED_FLOOR_DEF,
  parameter int VTOL_SUPPORT    = ags_pkg::VTOL_SUPPORT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // speed_valid[0] airspeed[16:1] armed[17] vtol_active[18] throttle_cmd[26:19]
  // sensor_in_use[27] in_takeoff[28], zero to 31
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // gain_scale[15:0] decay_integrators[16] peak_airspeed[32:17], zero to 39
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  ags_pkg::ags_cmd_t  cmd;
  ags_pkg::ags_stat_t stat;
  logic        idle, in_fire, out_free;
  logic [14:0] unity_speed, min_airspeed, max_airspeed;
  logic [6:0]  cruise_throttle;
  logic        suppress_takeoff;
  logic [15:0] gain_scale, peak_airspeed;
  logic        decay_integrators;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = idle;
  assign in_fire       = s_axis_tvalid && idle;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      unity_speed      <= 15'd3840;
      min_airspeed     <= 15'd2304;
      max_airspeed     <= 15'd5632;
      cruise_throttle  <= 7'd45;
      suppress_takeoff <= 1'b0;
      m_axis_tvalid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          ags_pkg::REG_UNITY_SPEED:      unity_speed      <= cfg_data;
          ags_pkg::REG_MIN_AIRSPEED:     min_airspeed     <= cfg_data;
          ags_pkg::REG_MAX_AIRSPEED:     max_airspeed     <= cfg_data;
          ags_pkg::REG_CRUISE_THROTTLE:  cruise_throttle  <= cfg_data[6:0];
          ags_pkg::REG_SUPPRESS_TAKEOFF: suppress_takeoff <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.finish) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  ags_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_free(out_free),
    .stat(stat), .cmd(cmd), .idle(idle)
  );

  ags_dp #(.MIN_SPEED_FLOOR(MIN_SPEED_FLOOR), .VTOL_SUPPORT(VTOL_SUPPORT)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .unity_speed(unity_speed), .min_airspeed(min_airspeed),
    .max_airspeed(max_airspeed), .cruise_throttle(cruise_throttle),
    .suppress_takeoff(suppress_takeoff),
    .speed_valid(s_axis_tdata[0]), .airspeed(s_axis_tdata[16:1]),
    .armed(s_axis_tdata[17]), .vtol_active(s_axis_tdata[18]),
    .throttle_cmd(s_axis_tdata[26:19]), .sensor_in_use(s_axis_tdata[27]),
    .in_takeoff(s_axis_tdata[28]),
    .gain_scale(gain_scale), .decay_integrators(decay_integrators),
    .peak_airspeed(peak_airspeed)
  );

  assign m_axis_tdata = {7'd0, peak_airspeed, decay_integrators, gain_scale};

endmodule
